>>> sv/lpfc_pkg.sv
// Shared types and constants for the LRU page fault counter.
`timescale 1ns / 1ps

package lpfc_pkg;

   // Fixed field widths on the ports
   localparam int REQ_PAGE_W  = 16;
   localparam int RSP_TOTAL_W = 16;
   localparam int RSP_DATA_W  = 24;
   localparam int CSR_CAP_W   = 5;
   localparam int CAP_RESET   = 16;

   // Per-item command broadcast to every cell of the stack
   typedef struct packed {
      logic step;   // an item is taken this cycle
      logic clear;  // first item of a run: empty the stack first
      logic hit;    // page found somewhere in the stack
      logic full;   // occupancy at or above capacity
   } lpfc_cmd_type;

endpackage

>>> sv/lpfc_cell.sv
// One entry of the LRU stack: holds a page and its valid bit.
`timescale 1ns / 1ps

module lpfc_cell
   import lpfc_pkg::*;
#(
   parameter int PAGE_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lpfc_cmd_type         cmd,
   input  logic [PAGE_BITS-1:0] req_page,
   input  logic [PAGE_BITS-1:0] up_page,
   input  logic                 up_valid,
   input  logic                 match_up,
   output logic [PAGE_BITS-1:0] dn_page,
   output logic                 dn_valid,
   output logic                 match_dn,
   output logic                 valid_q
);

   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic                 valid_ff, valid_in;
   logic                 valid_eff;
   logic                 match;
   logic                 shift;

   assign valid_eff = valid_ff & ~cmd.clear;
   assign match     = valid_eff && (page_ff == req_page);
   assign match_dn  = match_up | match;

   // Take the neighbour's entry when this cell lies above the insertion point
   always_comb begin
      if (cmd.hit) begin
         shift = ~match_up;
      end else if (cmd.full) begin
         shift = valid_eff;
      end else begin
         shift = up_valid;
      end
      page_in  = page_ff;
      valid_in = valid_ff;
      if (cmd.step) begin
         valid_in = shift ? up_valid : valid_eff;
         page_in  = shift ? up_page : page_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
   end

   assign dn_page  = page_ff;
   assign dn_valid = valid_eff;
   assign valid_q  = valid_ff;

endmodule

>>> sv/lpfc_fault_ctr.sv
// Saturating fault counter with clear at the start of a run.
`timescale 1ns / 1ps

module lpfc_fault_ctr #(
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  clear,
   input  logic                  fault,
   output logic [COUNT_BITS-1:0] count_nx
);

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] base;

   always_comb begin
      base     = clear ? '0 : count_ff;
      count_nx = base;
      if (fault && (base != '1)) begin
         count_nx = base + COUNT_BITS'(1);
      end
      count_in = step ? count_nx : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

>>> sv/lru_page_fault_counter_unit.sv
// Top level: LRU page store as a stack of cells, fault counter, output register.
`timescale 1ns / 1ps
// An accepted request's response is registered in the output register.
// One item per cycle while the receiver keeps up; all cells compare and shift together.
// The hit search ripples through the cells, so the cell count sets the critical path.
// Reset (synchronous): empties the stack, zeroes the fault total, capacity back to 16.
// No clearing pass; a first-of-run item empties the stack in the same cycle it is taken.

module lru_page_fault_counter_unit
   import lpfc_pkg::*;
#(
   parameter int SLOTS      = 16,
   parameter int PAGE_BITS  = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_PAGE_W-1:0]  req_tdata,   // [15:0] page
   input  logic                   req_tuser,   // [0] first_of_run
   input  logic                   req_tlast,   // last_of_run
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [0] fault, [16:1] fault_total, rest zero
   output logic                   rsp_tlast,   // last
   // capacity register write
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_CAP_W-1:0]   csr_wdata    // capacity
);

   localparam int CAP_W     = $clog2(SLOTS + 1);
   localparam int CAP_RST_L = (CAP_RESET > SLOTS) ? SLOTS : CAP_RESET;

   // Capacity, held already clamped to 1..SLOTS
   logic [CAP_W-1:0] cap_lim_ff, cap_lim_in;

   logic                 req_fire;
   logic [PAGE_BITS-1:0] req_page;
   lpfc_cmd_type         cmd;
   logic                 full;

   // Links between neighbouring cells; index 0 is the request entering at the top
   logic [PAGE_BITS-1:0] link_page  [SLOTS+1];
   logic                 link_valid [SLOTS+1];
   logic                 match_chain[SLOTS+1];
   logic [SLOTS-1:0]     valid_vec;
   // Per-cell hit flags, for the duplicate check
   logic [SLOTS-1:0]     match_vec;

   logic [COUNT_BITS-1:0] count_nx;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_fault_ff;
   logic [RSP_TOTAL_W-1:0] rsp_total_ff;
   logic                   rsp_last_ff;

   // Accept whenever the output register is empty or being drained
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_fire   = req_tvalid & req_tready;
   assign req_page   = PAGE_BITS'(req_tdata);

   // Capacity register: clamp zero up to one and anything above SLOTS down
   assign csr_ready = 1'b1;

   always_comb begin
      cap_lim_in = cap_lim_ff;
      if (csr_valid) begin
         if (csr_wdata == '0) begin
            cap_lim_in = CAP_W'(1);
         end else if (int'(csr_wdata) > SLOTS) begin
            cap_lim_in = CAP_W'(SLOTS);
         end else begin
            cap_lim_in = CAP_W'(csr_wdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_lim_ff <= CAP_W'(CAP_RST_L);
      end else begin
         cap_lim_ff <= cap_lim_in;
      end
   end

   // Top of the stack: the requested page always enters as a valid entry
   assign link_page[0]   = req_page;
   assign link_valid[0]  = 1'b1;
   assign match_chain[0] = 1'b0;

   generate
      for (genvar g = 0; g < SLOTS; g++) begin : g_cell
         lpfc_cell #(
            .PAGE_BITS (PAGE_BITS)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .cmd      (cmd),
            .req_page (req_page),
            .up_page  (link_page[g]),
            .up_valid (link_valid[g]),
            .match_up (match_chain[g]),
            .dn_page  (link_page[g+1]),
            .dn_valid (link_valid[g+1]),
            .match_dn (match_chain[g+1]),
            .valid_q  (valid_vec[g])
         );
      end
   endgenerate

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match_vec[i] = link_valid[i+1] && (link_page[i+1] == req_page);
      end
   end

   // Valid entries sit contiguously from the top, so the stack is full
   // exactly when the entry at depth capacity-1 is valid
   always_comb begin
      full = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (link_valid[i+1] && ((i + 1) == int'(cap_lim_ff))) begin
            full = 1'b1;
         end
      end
   end

   always_comb begin
      cmd.step  = req_fire;
      cmd.clear = req_tuser;
      cmd.hit   = match_chain[SLOTS];
      cmd.full  = full;
   end

   lpfc_fault_ctr #(
      .COUNT_BITS (COUNT_BITS)
   ) u_fault_ctr (
      .clock    (clock),
      .reset    (reset),
      .step     (req_fire),
      .clear    (req_tuser),
      .fault    (~match_chain[SLOTS]),
      .count_nx (count_nx)
   );

   // Output register: load on accept, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_fault_ff <= ~match_chain[SLOTS];
         rsp_total_ff <= RSP_TOTAL_W'(count_nx);
         rsp_last_ff  <= req_tlast;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_TOTAL_W - 1){1'b0}}, rsp_total_ff, rsp_fault_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   // The stack never holds the same page twice
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("more than one cell matches the request");

   // Valid entries stay packed against the top of the stack
   a_packed: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec + SLOTS'(1)) & valid_vec) == '0)
      else $error("valid entries not contiguous");

   // The first request of a run always faults
   a_first_faults: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser) |=> rsp_fault_ff)
      else $error("first request of a run did not fault");

   // A hit leaves the occupancy unchanged
   a_hit_keeps: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_tuser && match_chain[SLOTS]) |=>
         ($countones(valid_vec) == $past($countones(valid_vec))))
      else $error("hit changed occupancy");
`endif

endmodule

>>> tb/sv/lru_fault_checker.sv
// Watches the request, response and capacity channels, predicts each response and compares.
`timescale 1ns / 1ps

module lru_fault_checker
   import lpfc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_PAGE_W-1:0]  req_tdata,
   input  logic                   req_tuser,
   input  logic                   req_tlast,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   rsp_tlast,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_CAP_W-1:0]   csr_wdata,
   output int                     fail_count,
   output int                     pending,
   output int                     checked,
   output int                     faults_seen
);

   localparam int STORE_SLOTS = 16;

   typedef struct packed {
      logic                   fault;
      logic [RSP_TOTAL_W-1:0] total;
      logic                   last;
   } fault_result_type;

   // Resident pages, most recent at the front
   logic [REQ_PAGE_W-1:0]  lru_order[$];
   logic [CSR_CAP_W-1:0]   capacity;
   logic [RSP_TOTAL_W-1:0] run_faults;
   fault_result_type       fault_result_q[$];
   int                     err_tally = 0;
   int                     checked_tally = 0;
   int                     fault_tally = 0;

   task automatic report_mismatch(input string what, input int want, input int got);
      err_tally++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
   endtask

   // Apply one request to the LRU order and queue the response it must give
   task automatic predict_page_access(input logic [REQ_PAGE_W-1:0] page,
                                      input logic first, input logic last);
      int               hit_at;
      int               eff_cap;
      fault_result_type res;
      if (first) begin
         lru_order.delete();
         run_faults = '0;
      end
      eff_cap = (capacity == 0) ? 1 : ((capacity > STORE_SLOTS) ? STORE_SLOTS : capacity);
      hit_at = -1;
      foreach (lru_order[i])
         if (lru_order[i] == page) hit_at = i;
      if (hit_at >= 0) begin
         lru_order.delete(hit_at);
      end else begin
         if (run_faults != '1) run_faults++;
         // Replace the oldest once occupancy reaches capacity, even if it is already above
         if (lru_order.size() >= eff_cap) void'(lru_order.pop_back());
      end
      lru_order.push_front(page);
      res.fault = (hit_at < 0);
      res.total = run_faults;
      res.last  = last;
      fault_result_q.push_back(res);
   endtask

   always @(posedge clock) begin
      fault_result_type want;
      if (reset) begin
         lru_order.delete();
         fault_result_q.delete();
         run_faults = '0;
         capacity   = CSR_CAP_W'(CAP_RESET);
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (fault_result_q.size() == 0) begin
               err_tally++;
               $display("%0t: unexpected response, expected none, actual %h",
                        $time, rsp_tdata);
            end else begin
               want = fault_result_q.pop_front();
               checked_tally++;
               if (rsp_tdata[0]) fault_tally++;
               if (rsp_tdata[0] !== want.fault)
                  report_mismatch("fault", want.fault, rsp_tdata[0]);
               if (rsp_tdata[RSP_TOTAL_W:1] !== want.total)
                  report_mismatch("fault_total", want.total, rsp_tdata[RSP_TOTAL_W:1]);
               if (rsp_tlast !== want.last)
                  report_mismatch("last", want.last, rsp_tlast);
               if (rsp_tdata[RSP_DATA_W-1:RSP_TOTAL_W+1] !== '0)
                  report_mismatch("padding", 0, rsp_tdata[RSP_DATA_W-1:RSP_TOTAL_W+1]);
            end
         end
         // A request taken at the same edge as a write still sees the old capacity
         if (req_tvalid && req_tready)
            predict_page_access(req_tdata, req_tuser, req_tlast);
         if (csr_valid && csr_ready)
            capacity = csr_wdata;
      end
      fail_count  <= err_tally;
      pending     <= fault_result_q.size();
      checked     <= checked_tally;
      faults_seen <= fault_tally;
   end

endmodule

>>> tb/sv/tb_lru_page_fault_counter_unit.sv
// Testbench top: clock, reset, stimulus and verdict for the LRU page fault counter.
`timescale 1ns / 1ps

module tb_lru_page_fault_counter_unit
   import lpfc_pkg::*;
();

   localparam int PHASES         = 10;
   localparam int PHASE_ITEMS    = 123;
   localparam int WATCHDOG_LIMIT = 4000;

   // Receiver stall patterns
   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_SELDOM,
      READY_PERIODIC
   } stall_mode_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_PAGE_W-1:0] req_tdata;    // [15:0] page
   logic                  req_tuser;    // [0] first_of_run
   logic                  req_tlast;    // last_of_run
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;    // [0] fault, [16:1] fault_total, rest zero
   logic                  rsp_tlast;    // last
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_CAP_W-1:0]  csr_wdata;    // capacity

   int                    fail_count;
   int                    pending;
   int                    checked;
   int                    faults_seen;

   int                    burst_left = 0;
   int                    cap_writes = 0;
   int                    idle_cycles = 0;
   stall_mode_type        stall_mode = READY_ALWAYS;
   int                    stall_left = 0;
   int                    stall_phase = 0;
   logic [REQ_PAGE_W-1:0] hot_pages[32];

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   lru_page_fault_counter_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   lru_fault_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .pending     (pending),
      .checked     (checked),
      .faults_seen (faults_seen)
   );

   // Receiver: switch between stall patterns at random intervals,
   // so back-pressure lands on hits, fills, evictions and run boundaries alike
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(32, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      stall_phase <= stall_phase + 1;
      case (stall_mode)
         READY_ALWAYS:   rsp_tready <= 1'b1;
         READY_MOSTLY:   rsp_tready <= ($urandom_range(0, 3) != 0);
         READY_SELDOM:   rsp_tready <= ($urandom_range(0, 9) < 3);
         READY_PERIODIC: rsp_tready <= (stall_phase % 5 != 4);
      endcase
   end

   // Watchdog: count cycles in which no channel moves an item
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout after %0d cycles without progress", WATCHDOG_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one request item and hold it until taken. Between bursts, drop valid for a
   // random gap; within a burst, replace the data at the accepting edge.
   task automatic send_item(input logic [REQ_PAGE_W-1:0] page, input logic first,
                            input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= page;
      req_tuser  <= first;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
   endtask

   // Stop sending and wait for every outstanding response to be checked
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write the capacity register; only called with the block idle
   task automatic write_capacity(input logic [CSR_CAP_W-1:0] cap);
      csr_valid <= 1'b1;
      csr_wdata <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cap_writes++;
   endtask

   initial begin
      logic [CSR_CAP_W-1:0] cap_plan[PHASES];
      logic [CSR_CAP_W-1:0] cap;
      logic [REQ_PAGE_W-1:0] page;
      logic                 first_f;
      logic                 last_f;
      logic                 resume;
      int                   eff_cap;
      int                   ws;
      int                   run_len;
      int                   sent;

      // Hold every input at a known value from time zero
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      req_tlast  <= 1'b0;
      csr_valid  <= 1'b0;
      csr_wdata  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset capacity, extreme page numbers, hits, last without first
      send_item(16'h0000, 1'b1, 1'b0);
      send_item(16'hFFFF, 1'b0, 1'b0);
      send_item(16'h0000, 1'b0, 1'b0);
      send_item(16'h5555, 1'b0, 1'b0);
      send_item(16'hAAAA, 1'b0, 1'b1);
      send_item(16'hFFFF, 1'b0, 1'b0);
      settle();

      // Three slots: fill, hit, then evict the least recent page three times over
      write_capacity(5'd3);
      send_item(16'd1, 1'b1, 1'b0);
      send_item(16'd2, 1'b0, 1'b0);
      send_item(16'd3, 1'b0, 1'b0);
      send_item(16'd1, 1'b0, 1'b0);
      send_item(16'd4, 1'b0, 1'b0);
      send_item(16'd2, 1'b0, 1'b0);
      send_item(16'd3, 1'b0, 1'b1);
      settle();

      // Capacity zero behaves as one slot
      write_capacity(5'd0);
      send_item(16'd7, 1'b1, 1'b0);
      send_item(16'd7, 1'b0, 1'b0);
      send_item(16'd8, 1'b0, 1'b0);
      send_item(16'd7, 1'b0, 1'b1);
      settle();

      // Capacity above the slot count saturates
      write_capacity(5'd31);
      send_item(16'd9, 1'b1, 1'b0);
      send_item(16'd10, 1'b0, 1'b0);
      send_item(16'd9, 1'b0, 1'b1);
      settle();

      // Random phases: mostly well-formed runs over a small hot set so that hits,
      // fills and evictions all occur; some runs resume the previous store without a
      // first flag, and a few stray first/last flags break runs up
      cap_plan = '{5'd16, 5'd1, 5'd2, 5'd4, 5'd8, 5'd15, 5'd0, 5'd17, 5'd31, 5'd5};
      cap_plan[PHASES-1] = 5'($urandom_range(0, 31));
      for (int ph = 0; ph < PHASES; ph++) begin
         cap = cap_plan[ph];
         write_capacity(cap);
         eff_cap = (cap == 0) ? 1 : ((cap > 16) ? 16 : cap);
         foreach (hot_pages[i]) hot_pages[i] = REQ_PAGE_W'($urandom);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            run_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
            if (run_len > PHASE_ITEMS - sent) run_len = PHASE_ITEMS - sent;
            resume  = ($urandom_range(0, 4) == 0);
            ws = eff_cap + $urandom_range(0, 6) - 2;
            if (ws < 1) ws = 1;
            if (ws > 32) ws = 32;
            for (int k = 0; k < run_len; k++) begin
               first_f = ((k == 0) && !resume) || ($urandom_range(0, 49) == 0);
               last_f  = (k == run_len - 1) || ($urandom_range(0, 49) == 0);
               if ($urandom_range(0, 99) < 85)
                  page = hot_pages[$urandom_range(0, ws - 1)];
               else
                  page = REQ_PAGE_W'($urandom);
               send_item(page, first_f, last_f);
               sent++;
            end
         end
         settle();
      end

      $display("Covered %0d requests (%0d faults, %0d hits) over %0d capacity writes,",
               checked, faults_seen, checked - faults_seen, cap_writes);
      $display("with capacities 0 to 31, LRU eviction, resumed runs and stray run flags.");
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
